@@ design/bbrf_pkg.sv @@
// Package for the binomial blur row filter.
// Holds item structs, controller/datapath command structs and fixed widths.
// No dependencies.
package bbrf_pkg;

	localparam int MAX_RADIUS_DEF = 12;
	localparam int PIXEL_W        = 32;
	localparam int CHAN_W         = 8;
	localparam int NUM_CHAN       = PIXEL_W / CHAN_W;
	localparam int RADIUS_W       = 4;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_in;
		logic               end_of_row;
	} pixel_item_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_out;
		logic               last_out;
	} result_item_t;

	typedef struct packed {
		logic shift_pixel;
		logic shift_zero;
		logic clear_win;
		logic acc_en;
		logic acc_first;
		logic load_out;
		logic last;
		logic build_start;
		logic build_step;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

@@ design/bbrf_ctrl.sv @@
// Controller for the binomial blur row filter: sequences accept,
// tap accumulation, result load, end-of-row flush and tap rebuild.
// Depends on bbrf_pkg.
module bbrf_ctrl import bbrf_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	localparam int IDX_W = $clog2(2 * MAX_RADIUS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  logic                src_eor,
	output logic                src_stall,
	input  logic                cfg_valid,
	input  logic [RADIUS_W-1:0] cfg_data,
	output logic                cfg_ready,
	output dp_cmd_t             cmd,
	output logic [IDX_W-1:0]    tap_idx,
	output logic [IDX_W-1:0]    taps_n,
	input  dp_status_t          status
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] build_cnt_q;
	logic [IDX_W-1:0] d_q;
	logic [IDX_W-1:0] flush_q;
	logic             eor_q;
	logic             building;
	logic             accept;
	logic             cfg_wr;
	logic [IDX_W-1:0] new_n;

	assign building  = (build_cnt_q != n_q);
	assign src_stall = !((state_q == ST_IDLE) && !building);
	assign accept    = src_valid && !src_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// saturate the radius, kernel spans 2R+1 taps
	assign new_n = (int'(cfg_data) > MAX_RADIUS) ? IDX_W'(2 * MAX_RADIUS)
	                                              : IDX_W'(2 * int'(cfg_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			build_cnt_q <= '0;
		end else if (cfg_wr) begin
			n_q         <= new_n;
			build_cnt_q <= '0;
		end else if (building) begin
			build_cnt_q <= build_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q     <= '0;
			flush_q <= '0;
			eor_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						eor_q   <= src_eor;
						flush_q <= src_eor ? n_q : '0;
						d_q     <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (d_q == n_q) begin
						state_q <= ST_DONE;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (status.out_free) begin
						if (flush_q != '0) begin
							flush_q <= flush_q - 1'b1;
							d_q     <= '0;
							state_q <= ST_ACC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.shift_pixel = accept;
		cmd.acc_en      = (state_q == ST_ACC);
		cmd.acc_first   = (d_q == '0);
		cmd.load_out    = (state_q == ST_DONE) && status.out_free;
		cmd.last        = eor_q && (flush_q == '0);
		// flush: push a zero behind each result until the count runs out
		cmd.shift_zero  = cmd.load_out && (flush_q != '0);
		cmd.clear_win   = cmd.load_out && eor_q && (flush_q == '0);
		cmd.build_start = cfg_wr;
		cmd.build_step  = building && !cfg_wr;
	end

	assign tap_idx = d_q;
	assign taps_n  = n_q;

endmodule

@@ design/bbrf_datapath.sv @@
// Datapath for the binomial blur row filter: pixel window, Pascal tap
// weights, four-channel multiply-accumulate and the output register.
// Depends on bbrf_pkg.
module bbrf_datapath import bbrf_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	localparam int DEPTH = 2 * MAX_RADIUS + 1,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int WGT_W = 2 * MAX_RADIUS,
	localparam int SUM_W = WGT_W + CHAN_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PIXEL_W-1:0] pixel_in,
	input  dp_cmd_t            cmd,
	input  logic [IDX_W-1:0]   tap_idx,
	input  logic [IDX_W-1:0]   taps_n,
	output dp_status_t         status,
	output logic               dst_valid,
	input  logic               dst_stall,
	output result_item_t       dst_data
);

	logic [PIXEL_W-1:0] window_q [DEPTH];
	logic [WGT_W-1:0]   taps_q   [DEPTH];
	logic [SUM_W-1:0]   acc_q    [NUM_CHAN];
	logic [PIXEL_W-1:0] sel_px;
	logic [WGT_W-1:0]   sel_w;
	logic [PIXEL_W-1:0] blurred;
	logic               dst_valid_q;
	result_item_t       dst_data_q;

	// newest pixel at index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				window_q[k] <= '0;
			end
		end else if (cmd.clear_win) begin
			for (int k = 0; k < DEPTH; k++) begin
				window_q[k] <= '0;
			end
		end else if (cmd.shift_pixel || cmd.shift_zero) begin
			for (int k = 1; k < DEPTH; k++) begin
				window_q[k] <= window_q[k-1];
			end
			window_q[0] <= cmd.shift_pixel ? pixel_in : '0;
		end
	end

	// one Pascal step per cycle: row m becomes row m+1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k < DEPTH; k++) begin
				taps_q[k] <= '0;
			end
			taps_q[0] <= WGT_W'(1);
		end else if (cmd.build_start) begin
			for (int k = 1; k < DEPTH; k++) begin
				taps_q[k] <= '0;
			end
			taps_q[0] <= WGT_W'(1);
		end else if (cmd.build_step) begin
			for (int k = 1; k < DEPTH; k++) begin
				taps_q[k] <= taps_q[k] + taps_q[k-1];
			end
		end
	end

	assign sel_px = window_q[tap_idx];
	assign sel_w  = taps_q[tap_idx];

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				acc_q[c] <= (cmd.acc_first ? '0 : acc_q[c])
				            + SUM_W'(sel_w) * SUM_W'(sel_px[c*CHAN_W +: CHAN_W]);
			end
		end
	end

	// divide by the kernel weight 2^n and keep the low channel bits
	always_comb begin
		logic [SUM_W-1:0] shifted;
		blurred = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			shifted                   = acc_q[c] >> taps_n;
			blurred[c*CHAN_W +: CHAN_W] = shifted[CHAN_W-1:0];
		end
	end

	assign status.out_free = !dst_valid_q || !dst_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			dst_data_q.pixel_out <= blurred;
			dst_data_q.last_out  <= cmd.last;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

endmodule

@@ design/binomial_blur_row_filter.sv @@
// Binomial blur over one row of ARGB pixels. Each channel is filtered with
// row 2R of Pascal's triangle (R = radius, saturated at MAX_RADIUS), divided
// by 2^(2R), and pixels outside the row read as zero. An accepted pixel has
// its result built tap by tap in the accumulate state through the
// multiply-accumulate (one tap per cycle, four channels in parallel) and
// then loaded into the output register in the done state; no new pixel is
// taken before that load. The end-of-row pixel is followed by 2R flush
// results, the last result of the row flagged last_out; the window then
// clears. A radius write rebuilds the tap weights with one Pascal step per
// cycle and holds off input until the rebuild is done. Output stall holds
// the result register and pauses the sequence.
// Depends on bbrf_pkg, bbrf_ctrl and bbrf_datapath.
module binomial_blur_row_filter import bbrf_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  pixel_item_t         src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output result_item_t        dst_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RADIUS_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(2 * MAX_RADIUS + 1);

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [IDX_W-1:0] tap_idx;
	logic [IDX_W-1:0] taps_n;

	bbrf_ctrl #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_eor   (src_data.end_of_row),
		.src_stall (src_stall),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.tap_idx   (tap_idx),
		.taps_n    (taps_n),
		.status    (status)
	);

	bbrf_datapath #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (src_data.pixel_in),
		.cmd       (cmd),
		.tap_idx   (tap_idx),
		.taps_n    (taps_n),
		.status    (status),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

@@ design/bbrf_checker.sv @@
// Port-level checks for the binomial blur row filter, bound to the top level.
// Depends on bbrf_pkg and binomial_blur_row_filter.
module bbrf_checker import bbrf_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_stall,
	input pixel_item_t         src_data,
	input logic                dst_valid,
	input logic                dst_stall,
	input result_item_t        dst_data,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [RADIUS_W-1:0] cfg_data
);

	// a stalled result holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("stalled result changed or dropped");

	// a stalled input item holds
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_data))
		else $error("stalled input item changed or dropped");

	// the block works on one item at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("input accepted in back-to-back cycles");

	// a nonzero radius write rebuilds the taps before the next item
	a_rebuild_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_data != '0) |=> src_stall)
		else $error("input accepted while tap weights rebuild");

endmodule

bind binomial_blur_row_filter bbrf_checker u_bbrf_checker (.*);

@@ dv/tb_binomial_blur_row_filter.sv @@
// Testbench for binomial_blur_row_filter: clocked driver and monitor around the block,
// with a built-in predictor of the per-channel binomial row blur.
// Depends on bbrf_pkg and the binomial_blur_row_filter RTL.
module tb_binomial_blur_row_filter;
	import bbrf_pkg::*;

	localparam int WIN_DEPTH = 2 * MAX_RADIUS_DEF + 1;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 2 * MAX_RADIUS_DEF + 4;
	localparam int RANDOM_ITEMS = 500;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_stall;
	pixel_item_t         src_data = '0;
	logic                dst_valid;
	logic                dst_stall = 1'b0;
	result_item_t        dst_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RADIUS_W-1:0] cfg_data = '0;

	pixel_item_t  pending_px[$];
	result_item_t blurred_q[$];

	logic [PIXEL_W-1:0] blur_window [0:WIN_DEPTH-1];
	longint unsigned    tap_w [0:WIN_DEPTH-1];
	logic [RADIUS_W-1:0] radius_now;

	bit src_took = 1'b0;
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int fed_items = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	binomial_blur_row_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data (dst_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int eff_radius();
		return (radius_now > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius_now);
	endfunction

	function automatic void rebuild_taps();
		int n;
		longint unsigned c;
		n = 2 * eff_radius();
		c = 1;
		for (int k = 0; k < WIN_DEPTH; k++)
			tap_w[k] = 0;
		for (int k = 0; k <= n; k++) begin
			tap_w[k] = c;
			c = c * longint'(n - k) / longint'(k + 1);
		end
	endfunction

	function automatic logic [PIXEL_W-1:0] kernel_out();
		int n;
		longint unsigned sum;
		logic [PIXEL_W-1:0] res;
		n = 2 * eff_radius();
		res = '0;
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			sum = 0;
			for (int d = 0; d <= n; d++)
				sum += tap_w[d] * longint'(blur_window[d][ch*CHAN_W +: CHAN_W]);
			res[ch*CHAN_W +: CHAN_W] = CHAN_W'(sum >> n);
		end
		return res;
	endfunction

	function automatic void shift_window(logic [PIXEL_W-1:0] px);
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			blur_window[i] = blur_window[i-1];
		blur_window[0] = px;
	endfunction

	// Queue every output that one accepted pixel causes, flush included.
	function automatic void blur_pixel(pixel_item_t it);
		int flush;
		result_item_t r;
		flush = 2 * eff_radius();
		shift_window(it.pixel_in);
		r.pixel_out = kernel_out();
		r.last_out = it.end_of_row && (flush == 0);
		blurred_q.push_back(r);
		if (it.end_of_row) begin
			for (int f = 0; f < flush; f++) begin
				shift_window('0);
				r.pixel_out = kernel_out();
				r.last_out = (f + 1 == flush);
				blurred_q.push_back(r);
			end
			for (int i = 0; i < WIN_DEPTH; i++)
				blur_window[i] = '0;
		end
	endfunction

	function automatic void report_fail(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic [PIXEL_W-1:0] rand_pixel();
		logic [PIXEL_W-1:0] px;
		case ($urandom_range(7))
			0: px = '0;
			1: px = '1;
			2: begin
				for (int ch = 0; ch < NUM_CHAN; ch++)
					px[ch*CHAN_W +: CHAN_W] = $urandom_range(1) ? 8'hff : 8'h00;
			end
			default: px = $urandom;
		endcase
		return px;
	endfunction

	function automatic logic [RADIUS_W-1:0] pick_radius();
		// Keep most rows on small radii; large ones are slow.
		if ($urandom_range(9) < 7)
			return RADIUS_W'($urandom_range(4));
		return RADIUS_W'($urandom_range(15, 5));
	endfunction

	task automatic push_px(logic [PIXEL_W-1:0] px, bit eor);
		pixel_item_t it;
		it.pixel_in = px;
		it.end_of_row = eor;
		pending_px.push_back(it);
		fed_items++;
	endtask

	task automatic push_row(int len, bit close);
		for (int i = 0; i < len; i++)
			push_px(rand_pixel(), close && (i == len - 1));
	endtask

	// Block until every item is taken and every result is back, then settle.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_px.size() != 0 || src_valid || blurred_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_radius(logic [RADIUS_W-1:0] r);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Driver: inputs move on the falling edge only.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!src_valid || src_took) begin
				if (pending_px.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					src_data <= pending_px.pop_front();
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
			dst_stall <= ($urandom_range(99) < dst_idle_pct);
		end
	end

	// Monitor: sample handshakes on the rising edge, predict and check.
	always @(posedge clk) begin
		result_item_t want;
		src_took <= src_valid && !src_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				radius_now = cfg_data;
				rebuild_taps();
			end
			if (src_valid && !src_stall)
				blur_pixel(src_data);
			if (dst_valid && !dst_stall) begin
				if (blurred_q.size() == 0) begin
					report_fail($sformatf("unexpected result: pixel %h last %b",
						dst_data.pixel_out, dst_data.last_out));
				end else begin
					want = blurred_q.pop_front();
					if (want.pixel_out !== dst_data.pixel_out ||
					    want.last_out !== dst_data.last_out)
						report_fail($sformatf(
							"mismatch: expected pixel %h last %b, got pixel %h last %b",
							want.pixel_out, want.last_out,
							dst_data.pixel_out, dst_data.last_out));
				end
			end
			if ((cfg_valid && cfg_ready) || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("tb_binomial_blur_row_filter: done, errors");
					$finish;
				end
			end
		end
	end

	initial begin
		int rows;
		int len;
		radius_now = '0;
		for (int i = 0; i < WIN_DEPTH; i++)
			blur_window[i] = '0;
		rebuild_taps();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		src_idle_pct = 24;
		dst_idle_pct = 60;

		// Radius zero: pass-through, end of row gives one flagged output.
		push_px(32'h0000_0000, 1'b0);
		push_px(32'hffff_ffff, 1'b0);
		push_px(32'h1234_5678, 1'b1);
		wait_idle();
		set_radius(4'd1);
		push_px(32'hff00_ff00, 1'b0);
		push_px(32'h00ff_00ff, 1'b0);
		push_px(32'h8080_8080, 1'b1);
		wait_idle();
		// Change the radius with a row half done.
		set_radius(4'd2);
		push_px(32'hffff_ffff, 1'b0);
		push_px(32'hffff_ffff, 1'b0);
		wait_idle();
		set_radius(4'd3);
		push_px(32'hffff_ffff, 1'b0);
		push_px(32'h0102_0304, 1'b1);
		wait_idle();
		// Above the maximum the radius saturates.
		set_radius(4'd15);
		push_px(32'hffff_ffff, 1'b1);
		push_px(32'hffff_ffff, 1'b0);
		push_px(32'h0000_0000, 1'b0);
		push_px(32'hffff_ffff, 1'b1);
		wait_idle();
		set_radius(4'd12);
		push_px(32'hffff_ffff, 1'b1);
		wait_idle();
		set_radius(4'd13);
		push_px(32'h7f7f_7f7f, 1'b1);
		wait_idle();
		set_radius(4'd0);
		push_px(32'hffff_ffff, 1'b1);

		fed_items = 0;
		while (fed_items < RANDOM_ITEMS) begin
			if (fed_items >= 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end else if (fed_items >= RANDOM_ITEMS / 3) begin
				src_idle_pct = 60;
				dst_idle_pct = 24;
			end
			wait_idle();
			set_radius(pick_radius());
			rows = $urandom_range(4, 1);
			for (int r = 0; r < rows; r++) begin
				len = ($urandom_range(15) == 0) ? $urandom_range(40, 16)
				                                : $urandom_range(10, 1);
				if (len > 1 && $urandom_range(7) == 0) begin
					push_row(len / 2, 1'b0);
					wait_idle();
					set_radius(pick_radius());
					push_row(len - len / 2, 1'b1);
				end else begin
					push_row(len, 1'b1);
				end
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("tb_binomial_blur_row_filter: done, clean");
		else
			$display("tb_binomial_blur_row_filter: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
design/bbrf_pkg.sv
design/bbrf_ctrl.sv
design/bbrf_datapath.sv
design/binomial_blur_row_filter.sv
design/bbrf_checker.sv
dv/tb_binomial_blur_row_filter.sv
